// ===== hw/rtl/gcd_by_prime_factors_defines.svh =====
// ----------------------------------------------------------------------------
// gcd_by_prime_factors_defines.svh
// Assertion macros used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef GCD_BY_PRIME_FACTORS_DEFINES_SVH
`define GCD_BY_PRIME_FACTORS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBPF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcd_by_prime_factors: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GBPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gcd_by_prime_factors: next-cycle check failed");

`endif

// ===== hw/rtl/gbpf_pkg.sv =====
// ----------------------------------------------------------------------------
// gbpf_pkg
// Widths shared by the gcd block and its checker.
// ----------------------------------------------------------------------------
package gbpf_pkg;

    localparam int OPERAND_WIDTH = 31;
    // Counter over the quotient bits of one serial division.
    localparam int CNT_W = $clog2(OPERAND_WIDTH);

endpackage

// ===== hw/rtl/gcd_by_prime_factors.sv =====
// Operation: one serial division per trial divisor of operand_a plus one per factor found and a
//   final one; worst case (a prime near 2^31) about 23200 divisions. A zero operand skips the
//   factoring and all divisions.
// Flow: one beat at a time; no new pair is taken until the last result is in the output register.
// Reset: synchronous, active low; clears the sequencer, the divider bit count and the output
//   valid flag.
// ----------------------------------------------------------------------------
// gcd_by_prime_factors
// Greatest common divisor by trial-division factoring with a bit-serial divider.
// ----------------------------------------------------------------------------
module gcd_by_prime_factors
    import gbpf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [OPERAND_WIDTH-1:0] i_operand_a,
    input  logic [OPERAND_WIDTH-1:0] i_operand_b,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [OPERAND_WIDTH-1:0] o_gcd_value,
    output logic                     o_zero_operand
);

    localparam int W = OPERAND_WIDTH;

    // Sequencer codes.
    localparam logic [2:0] S_IDLE   = 3'd0;  // wait for an input beat
    localparam logic [2:0] S_CHECK  = 3'd1;  // pick the next division
    localparam logic [2:0] S_DIV_A  = 3'd2;  // v / d
    localparam logic [2:0] S_EVAL_A = 3'd3;  // act on v / d
    localparam logic [2:0] S_DIV_B  = 3'd4;  // b_rem / factor
    localparam logic [2:0] S_EVAL_B = 3'd5;  // act on b_rem / factor
    localparam logic [2:0] S_DIV_G  = 3'd6;  // b_orig / b_rem gives the gcd
    localparam logic [2:0] S_DONE   = 3'd7;  // hand the result to the output stage

    logic [2:0]       r_state, n_state;

    // Factoring state: v is what is left of a, d the trial divisor.
    // b_rem is b with every common factor removed, so b_orig / b_rem is the
    // product of the common prime factors.
    logic [W-1:0]     r_v, n_v;
    logic [W-1:0]     r_d, n_d;
    logic [W-1:0]     r_brem, n_brem;
    logic [W-1:0]     r_borig, n_borig;
    logic             r_last, n_last;     // leftover prime under test, then finish
    logic             r_zero, n_zero;

    // Bit-serial restoring divider: r_quo shifts the dividend out at the top
    // and the quotient in at the bottom, one bit per cycle.
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_dsr, n_dsr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [W-1:0]     r_out_gcd, n_out_gcd;
    logic             r_out_zero, n_out_zero;

    logic [W:0]       rem_sh;
    logic [W:0]       rem_diff;
    logic             take;
    logic             in_beat;

    assign o_in_ready     = (r_state == S_IDLE);
    assign in_beat        = i_in_valid && o_in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_gcd_value    = r_out_gcd;
    assign o_zero_operand = r_out_zero;

    // One divider step: shift in the next dividend bit, subtract if it fits.
    assign rem_sh   = {r_rem, r_quo[W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dsr};
    assign take     = (rem_sh >= {1'b0, r_dsr});

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_d         = r_d;
        n_brem      = r_brem;
        n_borig     = r_borig;
        n_last      = r_last;
        n_zero      = r_zero;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dsr       = r_dsr;
        n_cnt       = r_cnt;
        n_out_gcd   = r_out_gcd;
        n_out_zero  = r_out_zero;
        n_out_valid = r_out_valid && !i_out_ready;  // drop once the beat is taken

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_v     = i_operand_a;
                    n_brem  = i_operand_b;
                    n_borig = i_operand_b;
                    n_d     = W'(2);
                    n_last  = 1'b0;
                    if (i_operand_a == '0 || i_operand_b == '0) begin
                        // No factoring: report zero with the flag set.
                        n_zero  = 1'b1;
                        n_quo   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_zero  = 1'b0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_rem = '0;
                n_cnt = '0;
                if (r_v == W'(1)) begin
                    // a fully factored: gcd = b_orig / b_rem.
                    n_quo   = r_borig;
                    n_dsr   = r_brem;
                    n_state = S_DIV_G;
                end else begin
                    n_quo   = r_v;
                    n_dsr   = r_d;
                    n_state = S_DIV_A;
                end
            end
            S_DIV_A, S_DIV_B, S_DIV_G: begin
                n_rem = take ? rem_diff[W-1:0] : rem_sh[W-1:0];
                n_quo = {r_quo[W-2:0], take};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(W - 1)) begin
                    n_cnt = '0;
                    case (r_state)
                        S_DIV_A: n_state = S_EVAL_A;
                        S_DIV_B: n_state = S_EVAL_B;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_EVAL_A: begin
                n_rem = '0;
                if (r_rem == '0) begin
                    // d divides v: keep d as a factor, test it against b.
                    n_v     = r_quo;
                    n_quo   = r_brem;
                    n_dsr   = r_d;
                    n_state = S_DIV_B;
                end else if (r_d == W'(2)) begin
                    n_d     = W'(3);
                    n_state = S_CHECK;
                end else if (r_d > r_quo) begin
                    // d*d > v: what is left of v is prime.
                    n_quo   = r_brem;
                    n_dsr   = r_v;
                    n_last  = 1'b1;
                    n_state = S_DIV_B;
                end else begin
                    n_d     = r_d + W'(2);
                    n_state = S_CHECK;
                end
            end
            S_EVAL_B: begin
                if (r_rem == '0) begin
                    n_brem = r_quo;
                end
                if (r_last) begin
                    n_v = W'(1);
                end
                n_state = S_CHECK;
            end
            S_DONE: begin
                // Hold until the output stage is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_gcd   = r_quo;
                    n_out_zero  = r_zero;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_d        <= n_d;
        r_brem     <= n_brem;
        r_borig    <= n_borig;
        r_last     <= n_last;
        r_zero     <= n_zero;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dsr      <= n_dsr;
        r_out_gcd  <= n_out_gcd;
        r_out_zero <= n_out_zero;
    end

endmodule

// ===== hw/rtl/gbpf_checker.sv =====
// ----------------------------------------------------------------------------
// gbpf_checker
// Port-level checks on the gcd block, bound to its top level.
// ----------------------------------------------------------------------------
`include "gcd_by_prime_factors_defines.svh"

module gbpf_checker
    import gbpf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     o_in_ready,
    input  logic [OPERAND_WIDTH-1:0] i_operand_a,
    input  logic [OPERAND_WIDTH-1:0] i_operand_b,
    input  logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  logic [OPERAND_WIDTH-1:0] o_gcd_value,
    input  logic                     o_zero_operand
);

    // A stalled result beat holds.
    `GBPF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_gcd_value) && $stable(o_zero_operand))

    // A flagged result carries zero, an unflagged one a nonzero gcd.
    `GBPF_ASSERT_SAME(a_zero_gives_zero, o_out_valid && o_zero_operand, o_gcd_value == '0)
    `GBPF_ASSERT_SAME(a_gcd_nonzero, o_out_valid && !o_zero_operand, o_gcd_value != '0)

    // The block is busy in the cycle after it takes a beat.
    `GBPF_ASSERT_NEXT(a_busy_after_beat, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind gcd_by_prime_factors gbpf_checker u_gbpf_checker (.*);

// ===== tb/gcd_by_prime_factors_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_by_prime_factors_check
// Watches the operand and result channels of the gcd block, works out the
// gcd of every accepted operand pair by prime factoring and compares each
// returned result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module gcd_by_prime_factors_check
    import gbpf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [OPERAND_WIDTH-1:0] i_operand_a,
    input  logic [OPERAND_WIDTH-1:0] i_operand_b,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [OPERAND_WIDTH-1:0] i_gcd_value,
    input  logic                     i_zero_operand,
    output int unsigned              o_fail_count,
    output int unsigned              o_pending
);

    localparam int FACTOR_LIMIT = 32;
    localparam int REPORT_LIMIT = 10;

    typedef longint unsigned prime_list_t [FACTOR_LIMIT];

    typedef struct {
        logic [OPERAND_WIDTH-1:0] operand_a;
        logic [OPERAND_WIDTH-1:0] operand_b;
        logic [OPERAND_WIDTH-1:0] gcd_value;
        logic                     zero_operand;
    } gcd_expect_t;

    gcd_expect_t gcd_q [$];
    gcd_expect_t want;
    int unsigned fail_count;

    // Trial division, 2 first and then odd divisors up to the square root;
    // a remainder above one is a prime of its own. Returns the list length.
    function automatic int split_primes(input longint unsigned value,
                                        output prime_list_t primes);
        longint unsigned rest;
        longint unsigned div;
        int n;
        rest = value;
        n = 0;
        for (int k = 0; k < FACTOR_LIMIT; k++) primes[k] = 0;
        while (rest > 1 && rest[0] == 1'b0) begin
            if (n < FACTOR_LIMIT) begin
                primes[n] = 2;
                n = n + 1;
            end
            rest = rest >> 1;
        end
        div = 3;
        while (rest > 1 && div <= rest / div) begin
            while (rest % div == 0) begin
                if (n < FACTOR_LIMIT) begin
                    primes[n] = div;
                    n = n + 1;
                end
                rest = rest / div;
            end
            div = div + 2;
        end
        if (rest > 1 && n < FACTOR_LIMIT) begin
            primes[n] = rest;
            n = n + 1;
        end
        return n;
    endfunction

    function automatic gcd_expect_t gcd_of_pair(input logic [OPERAND_WIDTH-1:0] a,
                                                input logic [OPERAND_WIDTH-1:0] b);
        prime_list_t     list_a;
        prime_list_t     list_b;
        int              len_a;
        int              len_b;
        int              ia;
        int              ib;
        longint unsigned product;
        gcd_expect_t     r;
        r.operand_a = a;
        r.operand_b = b;
        if (a == '0 || b == '0) begin
            r.gcd_value    = '0;
            r.zero_operand = 1'b1;
            return r;
        end
        len_a = split_primes(longint'(a), list_a);
        len_b = split_primes(longint'(b), list_b);
        // Walk both ascending lists and multiply in every shared factor.
        ia = 0;
        ib = 0;
        product = 1;
        while (ia < len_a && ib < len_b) begin
            if (list_a[ia] == list_b[ib]) begin
                product = product * list_a[ia];
                ia = ia + 1;
                ib = ib + 1;
            end else if (list_a[ia] < list_b[ib]) begin
                ia = ia + 1;
            end else begin
                ib = ib + 1;
            end
        end
        r.gcd_value    = OPERAND_WIDTH'(product);
        r.zero_operand = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Retire first: a result beat never belongs to a pair accepted
            // at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (gcd_q.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: unexpected result gcd %0d zero_operand %0b",
                                 $realtime, i_gcd_value, i_zero_operand);
                    fail_count = fail_count + 1;
                end else begin
                    want = gcd_q.pop_front();
                    if (i_gcd_value !== want.gcd_value ||
                        i_zero_operand !== want.zero_operand) begin
                        if (fail_count < REPORT_LIMIT) begin
                            if (i_gcd_value !== want.gcd_value)
                                $display("%0t: a=%0d b=%0d gcd expected %0d, got %0d",
                                         $realtime, want.operand_a, want.operand_b,
                                         want.gcd_value, i_gcd_value);
                            if (i_zero_operand !== want.zero_operand)
                                $display("%0t: a=%0d b=%0d zero_operand expected %0b, got %0b",
                                         $realtime, want.operand_a, want.operand_b,
                                         want.zero_operand, i_zero_operand);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end
            // Append the expectation for an accepted pair at the tail.
            if (i_in_valid && i_in_ready)
                gcd_q = {gcd_q, gcd_of_pair(i_operand_a, i_operand_b)};
        end
        o_fail_count <= fail_count;
        o_pending    <= gcd_q.size();
    end

endmodule

// ===== tb/gcd_by_prime_factors_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_by_prime_factors_test
// Stimulus and verdict for the prime-factoring gcd block: a directed set of
// corner pairs, then random pairs built mostly from small primes so that the
// trial division stays short, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module gcd_by_prime_factors_test
    import gbpf_pkg::*;
();

    localparam int              RANDOM_PAIRS = 100;
    localparam longint unsigned OPERAND_MAX  = (64'd1 << OPERAND_WIDTH) - 1;
    localparam int              DRAIN_CYCLES = 200;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [OPERAND_WIDTH-1:0] operand_a;
    logic [OPERAND_WIDTH-1:0] operand_b;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [OPERAND_WIDTH-1:0] gcd_value;
    logic                     zero_operand;
    int unsigned              fail_count;
    int unsigned              pending;

    // Stretches without idling on either side.
    bit          quiet = 1'b0;
    int unsigned sink_run = 0;

    int unsigned small_primes [11]   = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
    // Primes above the trial bound of the small set, kept moderate so the
    // trial division ends within a few hundred divisors.
    int unsigned moderate_primes [5] = '{257, 7919, 65537, 131071, 524287};

    gcd_by_prime_factors dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_operand_a    (operand_a),
        .i_operand_b    (operand_b),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_gcd_value    (gcd_value),
        .o_zero_operand (zero_operand)
    );

    gcd_by_prime_factors_check check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_operand_a    (operand_a),
        .i_operand_b    (operand_b),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_gcd_value    (gcd_value),
        .i_zero_operand (zero_operand),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    // Multiply random small primes into a start value, dropping any that
    // would overflow the operand width.
    function automatic longint unsigned grow_smooth(input longint unsigned start,
                                                    input int unsigned steps);
        longint unsigned v;
        longint unsigned p;
        v = start;
        repeat (steps) begin
            p = small_primes[$urandom_range(0, 10)];
            if (v * p <= OPERAND_MAX) v = v * p;
        end
        return v;
    endfunction

    // Result side: alternate ready runs and stalls of random length; hold
    // ready high through a quiet stretch.
    always @(posedge i_clk) begin
        if (sink_run != 0) begin
            sink_run <= sink_run - 1;
        end else begin
            out_ready <= quiet ? 1'b1 : !out_ready;
            sink_run  <= out_ready ? pick_gap() : $urandom_range(1, 40);
        end
    end

    // Present one operand pair and hold it until the beat is taken. A pair
    // that follows with no gap raises valid only once, at the accepting edge.
    task automatic send_pair(input longint unsigned a,
                             input longint unsigned b);
        int unsigned gap;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        operand_a <= a[OPERAND_WIDTH-1:0];
        operand_b <= b[OPERAND_WIDTH-1:0];
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Step past the edge of the last beat first, so the outstanding count
    // already includes it.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        longint unsigned a;
        longint unsigned b;
        longint unsigned common;
        longint unsigned big;
        int unsigned     kind;

        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        operand_a <= '0;
        operand_b <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero operands: flag raised, no factoring, so the widest prime is
        // safe here.
        send_pair(0, 0);
        send_pair(0, 31'h7fffffff);
        send_pair(31'h7fffffff, 0);
        send_pair(1, 0);
        // Operand of one: empty factor list, gcd is one.
        send_pair(1, 1);
        send_pair(1, 2147483646);
        send_pair(2147483646, 1);
        // Field extremes that factor quickly (largest prime 331).
        send_pair(2147483646, 2147483646);
        send_pair(2147483646, 1073741824);
        send_pair(1073741824, 1073741824);
        send_pair(1073741824, 536870912);
        // Leftover prime above the trial bound.
        send_pair(2 * 999983, 3 * 999983);
        send_pair(1024 * 999983, 7);
        send_pair(6 * 65537, 5 * 65537);
        send_pair(131071, 131071);
        // Shared factors with multiplicity, and plain coprime pairs.
        send_pair(49, 343);
        send_pair(45, 75);
        send_pair(1024, 59049);
        send_pair(2, 2);
        send_pair(3, 3);
        send_pair(2, 3);
        send_pair(1, 2);

        // Let the block run dry once before the random part.
        in_valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // Smooth pair around a random common part.
                common = grow_smooth(1, $urandom_range(0, 12));
                a = grow_smooth(common, $urandom_range(0, 30));
                b = grow_smooth(common, $urandom_range(0, 30));
            end else if (kind < 70) begin
                // Zero on one or both sides; the partner takes any bit pattern.
                a = $urandom() & OPERAND_MAX;
                b = $urandom() & OPERAND_MAX;
                if ($urandom_range(0, 4) == 0) begin
                    a = 0;
                    b = 0;
                end else if ($urandom_range(0, 1) == 1) begin
                    a = 0;
                end else begin
                    b = 0;
                end
            end else if (kind < 80) begin
                a = $urandom_range(1, 4095);
                b = $urandom_range(1, 4095);
            end else if (kind < 90) begin
                // Moderate prime left over after the small factors.
                big = moderate_primes[$urandom_range(0, 4)];
                a = grow_smooth(big, $urandom_range(0, 20));
                b = grow_smooth($urandom_range(0, 1) ? big : 1, $urandom_range(0, 20));
            end else begin
                a = 1;
                b = grow_smooth(1, $urandom_range(0, 30));
                if ($urandom_range(0, 1) == 1) begin
                    a = b;
                    b = 1;
                end
            end
            send_pair(a, b);
        end
        in_valid <= 1'b0;

        // Wait out the last result, then give any stray beat time to show.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Guard against a hung block: far beyond the slowest pair in this run.
    initial begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
